/* hdl/fbf_pkg.sv */
// ----------------------------------------------------------------------------
// fbf_pkg
// Shared widths, codes, types and helper functions for the fetch block former.
// ----------------------------------------------------------------------------
package fbf_pkg;

	localparam int PC_WIDTH     = 64;
	localparam int MAX_LINE_LOG = 8;
	localparam int LINE_WIDTH   = PC_WIDTH - 2;
	localparam int OFFSET_W     = MAX_LINE_LOG;
	localparam int CFG_W        = 4;
	localparam int LOG_W        = CFG_W;
	localparam int COUNT_W      = 9;
	localparam int BR_W         = 4;
	localparam int KIND_W       = 2;
	localparam int CUR_W        = ((OFFSET_W > COUNT_W) ? OFFSET_W : COUNT_W) + 1;
	localparam int CFG_IDX_W    = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_LOG_LINE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_COND = 1'd1;

	localparam logic [CFG_W-1:0] LOG_LINE_RESET = 4'd6;
	localparam logic [CFG_W-1:0] MAX_COND_RESET = 4'd7;
	localparam logic [LOG_W-1:0] MAX_LOG_CODE   = LOG_W'(MAX_LINE_LOG);

	localparam logic MODE_FLUSH = 1'b1;

	localparam logic [KIND_W-1:0] KIND_BRANCHY = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SEQ     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_JUMP    = 2'd2;

	typedef struct packed {
		logic                mode;
		logic [PC_WIDTH-1:0] pc;
		logic [PC_WIDTH-1:0] next_pc;
		logic                is_branch;
		logic                is_cond_branch;
		logic                taken_flag;
	} fbf_item_t;

	typedef struct packed {
		logic [CFG_W-1:0] log_line;
		logic [CFG_W-1:0] max_cond;
	} fbf_cfg_t;

	typedef struct packed {
		logic [PC_WIDTH-1:0]   start_pc;
		logic [COUNT_W-1:0]    instr_count;
		logic [BR_W-1:0]       cond_count;
		logic [BR_W-1:0]       exit_path;
		logic [PC_WIDTH-1:0]   next_block_pc;
		logic [LINE_WIDTH-1:0] start_line;
		logic [LINE_WIDTH-1:0] successor_line;
		logic                  has_predecessor;
		logic [LINE_WIDTH-1:0] pred_line;
		logic [BR_W-1:0]       pred_path;
		logic [KIND_W-1:0]     zero_block_kind;
		logic                  follows_zero_block;
	} fbf_result_t;

	function automatic logic [LOG_W-1:0] eff_log(input logic [CFG_W-1:0] v);
		return (v > MAX_LOG_CODE) ? MAX_LOG_CODE : v;
	endfunction

	function automatic logic [OFFSET_W-1:0] line_mask(input logic [LOG_W-1:0] lg);
		logic [OFFSET_W-1:0] ones;
		ones = '1;
		return ~(ones << lg);
	endfunction

	function automatic logic [LINE_WIDTH-1:0] line_of(input logic [PC_WIDTH-1:0] addr,
			input logic [LOG_W-1:0] lg);
		logic [PC_WIDTH-1:0] sh;
		sh = addr >> ({1'b0, lg} + 5'd2);
		return sh[LINE_WIDTH-1:0];
	endfunction

endpackage

/* hdl/fbf_core.sv */
// ----------------------------------------------------------------------------
// fbf_core
// Block tracking state and the close decision for one request per cycle while advance is high.
// ----------------------------------------------------------------------------
module fbf_core
	import fbf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  fbf_item_t   item,
	input  fbf_cfg_t    cfg,
	output logic        produce,
	output fbf_result_t result
);

	logic [PC_WIDTH-1:0]   block_start_q;
	logic [OFFSET_W-1:0]   start_offset_q;
	logic [COUNT_W-1:0]    instr_counter_q;
	logic [BR_W-1:0]       branch_counter_q;
	logic                  block_open_q;
	logic [PC_WIDTH-1:0]   previous_pc_q;
	logic                  previous_valid_q;
	logic [LINE_WIDTH-1:0] last_line_q;
	logic [BR_W-1:0]       last_path_q;
	logic                  last_valid_q;
	logic                  last_was_zero_q;

	logic [LOG_W-1:0]    eff;
	logic [OFFSET_W-1:0] mask;
	logic [PC_WIDTH-1:0] seq_pc;
	logic                flush;
	logic                taken;
	logic                line_done;
	logic                limit;
	logic                close;
	logic [PC_WIDTH-1:0] new_start;
	logic [OFFSET_W-1:0] new_offset;
	logic [COUNT_W-1:0]  base_cnt;
	logic [COUNT_W-1:0]  new_cnt;
	logic [BR_W-1:0]     new_bc;
	logic [CUR_W-1:0]    cur;
	logic [PC_WIDTH-1:0] sel_start;
	logic [COUNT_W-1:0]  sel_cnt;
	logic [BR_W-1:0]     sel_bc;
	logic                sel_taken;
	logic [PC_WIDTH-1:0] succ;
	logic [PC_WIDTH-1:0] seq_end;
	logic [BR_W-1:0]     path;

	always_comb begin
		eff        = eff_log(cfg.log_line);
		mask       = line_mask(eff);
		seq_pc     = previous_pc_q + PC_WIDTH'(4);
		flush      = (item.mode == MODE_FLUSH);
		// a pc break on a branch counts as taken
		taken      = item.is_branch &&
			(item.taken_flag || (previous_valid_q && (item.pc != seq_pc)));
		new_start  = block_open_q ? block_start_q : item.pc;
		new_offset = block_open_q ? start_offset_q : (item.pc[OFFSET_W+1:2] & mask);
		base_cnt   = block_open_q ? instr_counter_q : '0;
		new_cnt    = (base_cnt == '1) ? base_cnt : base_cnt + COUNT_W'(1);
		new_bc     = (item.is_cond_branch && (branch_counter_q != '1)) ?
			branch_counter_q + BR_W'(1) : branch_counter_q;
		cur        = CUR_W'(new_offset) + CUR_W'(new_cnt) - CUR_W'(1);
		line_done  = (cur >= CUR_W'(mask));
		limit      = item.is_cond_branch && (new_bc >= cfg.max_cond);

		if (flush) begin
			close     = block_open_q && previous_valid_q;
			sel_start = block_start_q;
			sel_cnt   = instr_counter_q;
			sel_bc    = branch_counter_q;
			sel_taken = 1'b0;
			succ      = seq_pc;
		end else begin
			close     = taken || line_done || limit;
			sel_start = new_start;
			sel_cnt   = new_cnt;
			sel_bc    = new_bc;
			sel_taken = taken;
			succ      = taken ? item.next_pc : item.pc + PC_WIDTH'(4);
		end

		path    = sel_taken ? sel_bc : '0;
		seq_end = sel_start + PC_WIDTH'({sel_cnt, 2'b00});

		result.start_pc           = sel_start;
		result.instr_count        = sel_cnt;
		result.cond_count         = sel_bc;
		result.exit_path          = path;
		result.next_block_pc      = succ;
		result.start_line         = line_of(sel_start, eff);
		result.successor_line     = line_of(succ, eff);
		result.has_predecessor    = last_valid_q;
		result.pred_line          = last_line_q;
		result.pred_path          = last_path_q;
		result.follows_zero_block = last_was_zero_q;
		if (sel_bc != '0) begin
			result.zero_block_kind = KIND_BRANCHY;
		end else if (succ == seq_end) begin
			result.zero_block_kind = KIND_SEQ;
		end else begin
			result.zero_block_kind = KIND_JUMP;
		end

		produce = close;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_start_q    <= '0;
			start_offset_q   <= '0;
			instr_counter_q  <= '0;
			branch_counter_q <= '0;
			block_open_q     <= 1'b0;
			previous_pc_q    <= '0;
			previous_valid_q <= 1'b0;
			last_line_q      <= '0;
			last_path_q      <= '0;
			last_valid_q     <= 1'b0;
			last_was_zero_q  <= 1'b0;
		end else if (advance) begin
			if (!flush) begin
				previous_pc_q    <= item.pc;
				previous_valid_q <= 1'b1;
				block_start_q    <= new_start;
				start_offset_q   <= new_offset;
			end
			if (close) begin
				block_open_q     <= 1'b0;
				instr_counter_q  <= '0;
				branch_counter_q <= '0;
				last_was_zero_q  <= (sel_bc == '0);
				last_line_q      <= result.start_line;
				last_path_q      <= path;
				last_valid_q     <= 1'b1;
			end else if (!flush) begin
				block_open_q     <= 1'b1;
				instr_counter_q  <= new_cnt;
				branch_counter_q <= new_bc;
			end
		end
	end

endmodule

/* hdl/fbf_result_reg.sv */
// ----------------------------------------------------------------------------
// fbf_result_reg
// Output register holding one finished block until it is taken.
// ----------------------------------------------------------------------------
module fbf_result_reg
	import fbf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  fbf_result_t d,
	input  logic        result_ready,
	output logic        valid_q,
	output fbf_result_t data_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= d;
		end
	end

endmodule

/* hdl/fetch_block_former.sv */
// a request is held in the input register; its block then loads the result register
// throughput: one request per cycle unless the result register is full and not taken, set by
//   the single input register and the combinational close logic in fbf_core
// a request waits in the input register while the result register is full and not taken
// reset: asynchronous, clears all block state and config to 6 / 7
// ----------------------------------------------------------------------------
// fetch_block_former
// Cuts a retired instruction trace into prediction blocks.
// ----------------------------------------------------------------------------
module fetch_block_former
	import fbf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  logic                  mode,
	input  logic [PC_WIDTH-1:0]   pc,
	input  logic [PC_WIDTH-1:0]   next_pc,
	input  logic                  is_branch,
	input  logic                  is_cond_branch,
	input  logic                  taken_flag,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [PC_WIDTH-1:0]   start_pc,
	output logic [COUNT_W-1:0]    instr_count,
	output logic [BR_W-1:0]       cond_count,
	output logic [BR_W-1:0]       exit_path,
	output logic [PC_WIDTH-1:0]   next_block_pc,
	output logic [LINE_WIDTH-1:0] start_line,
	output logic [LINE_WIDTH-1:0] successor_line,
	output logic                  has_predecessor,
	output logic [LINE_WIDTH-1:0] pred_line,
	output logic [BR_W-1:0]       pred_path,
	output logic [KIND_W-1:0]     zero_block_kind,
	output logic                  follows_zero_block
);

	fbf_cfg_t    cfg_q;
	fbf_item_t   item_s1;
	logic        valid_s1;
	logic        fire;
	logic        produce;
	fbf_result_t result;
	fbf_result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.log_line <= LOG_LINE_RESET;
			cfg_q.max_cond <= MAX_COND_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOG_LINE: cfg_q.log_line <= cfg_data;
				CFG_MAX_COND: cfg_q.max_cond <= cfg_data;
				default: ;
			endcase
		end
	end

	assign fire       = valid_s1 && (!result_valid || result_ready);
	assign item_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1.mode           <= mode;
			item_s1.pc             <= pc;
			item_s1.next_pc        <= next_pc;
			item_s1.is_branch      <= is_branch;
			item_s1.is_cond_branch <= is_cond_branch;
			item_s1.taken_flag     <= taken_flag;
		end
	end

	fbf_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (fire),
		.item    (item_s1),
		.cfg     (cfg_q),
		.produce (produce),
		.result  (result)
	);

	fbf_result_reg u_result (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (fire && produce),
		.d            (result),
		.result_ready (result_ready),
		.valid_q      (result_valid),
		.data_q       (result_q)
	);

	assign start_pc           = result_q.start_pc;
	assign instr_count        = result_q.instr_count;
	assign cond_count         = result_q.cond_count;
	assign exit_path          = result_q.exit_path;
	assign next_block_pc      = result_q.next_block_pc;
	assign start_line         = result_q.start_line;
	assign successor_line     = result_q.successor_line;
	assign has_predecessor    = result_q.has_predecessor;
	assign pred_line          = result_q.pred_line;
	assign pred_path          = result_q.pred_path;
	assign zero_block_kind    = result_q.zero_block_kind;
	assign follows_zero_block = result_q.follows_zero_block;

	// a held request stays put while the result register is blocked
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && result_valid && !result_ready |=> valid_s1 && $stable(item_s1))
		else $error("stage one request lost while output stalled");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (instr_count != '0))
		else $error("block with no instructions");

	a_kind_matches: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((cond_count == '0) == (zero_block_kind != KIND_BRANCHY)))
		else $error("zero-branch class disagrees with branch count");

	a_path_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((exit_path == '0) || (exit_path == cond_count)))
		else $error("exit path is neither fall through nor last branch");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fetch block former. A short table of directed
// trace requests is run first, then randomized instruction traces under several
// line size and branch limit settings. Every block the design emits is compared
// field by field against a predictor kept in the bench, with bursty requests,
// random result backpressure and one long result stall.
// ----------------------------------------------------------------------------
module tb_top
	import fbf_pkg::*;
;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 7;

	typedef enum int unsigned {SINK_OPEN, SINK_MOSTLY, SINK_SPARSE, SINK_PERIODIC} sink_style_t;

	typedef struct {
		fbf_item_t   req;
		bit          typed;
		fbf_result_t want;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_LOG_LINE;
	logic [CFG_W-1:0]      cfg_data = '0;
	logic                  item_valid = 1'b0;
	logic                  item_ready;
	logic                  mode = 1'b0;
	logic [PC_WIDTH-1:0]   pc = '0;
	logic [PC_WIDTH-1:0]   next_pc = '0;
	logic                  is_branch = 1'b0;
	logic                  is_cond_branch = 1'b0;
	logic                  taken_flag = 1'b0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	logic [PC_WIDTH-1:0]   start_pc;
	logic [COUNT_W-1:0]    instr_count;
	logic [BR_W-1:0]       cond_count;
	logic [BR_W-1:0]       exit_path;
	logic [PC_WIDTH-1:0]   next_block_pc;
	logic [LINE_WIDTH-1:0] start_line;
	logic [LINE_WIDTH-1:0] successor_line;
	logic                  has_predecessor;
	logic [LINE_WIDTH-1:0] pred_line;
	logic [BR_W-1:0]       pred_path;
	logic [KIND_W-1:0]     zero_block_kind;
	logic                  follows_zero_block;

	// predictor state
	logic [CFG_W-1:0]      cfg_log_line = LOG_LINE_RESET;
	logic [CFG_W-1:0]      cfg_max_cond = MAX_COND_RESET;
	logic [PC_WIDTH-1:0]   blk_start = '0;
	int unsigned           blk_offset = 0;
	int unsigned           blk_insts = 0;
	int unsigned           blk_conds = 0;
	bit                    blk_open = 1'b0;
	logic [PC_WIDTH-1:0]   prev_pc = '0;
	bit                    prev_ok = 1'b0;
	logic [LINE_WIDTH-1:0] prior_line = '0;
	logic [BR_W-1:0]       prior_path = '0;
	bit                    prior_ok = 1'b0;
	bit                    prior_zero = 1'b0;

	fbf_result_t           pending_blocks[$];
	dir_row_t              dir_rows[$];
	logic [PC_WIDTH-1:0]   trace_pc = '0;
	int unsigned           burst_left = 0;
	int unsigned           mismatches = 0;
	int unsigned           cycle_cnt = 0;
	bit                    hold_off_go = 1'b0;
	bit                    hold_off_done = 1'b0;
	logic [CFG_W-1:0]      ph_log [PHASES];
	logic [CFG_W-1:0]      ph_max [PHASES];

	fetch_block_former u_top (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	initial begin : watchdog
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("tb: failure");
		$finish;
	end

	function automatic int unsigned span_log();
		return (cfg_log_line > MAX_LINE_LOG) ? MAX_LINE_LOG : int'(cfg_log_line);
	endfunction

	function automatic logic [LINE_WIDTH-1:0] line_no(input logic [PC_WIDTH-1:0] a);
		logic [PC_WIDTH-1:0] s;
		s = a >> (span_log() + 2);
		return s[LINE_WIDTH-1:0];
	endfunction

	function automatic fbf_result_t retire_block(input logic [PC_WIDTH-1:0] succ, input bit tk);
		fbf_result_t r;
		logic [BR_W-1:0] path;
		path = tk ? BR_W'(blk_conds) : '0;
		r.start_pc           = blk_start;
		r.instr_count        = COUNT_W'(blk_insts);
		r.cond_count         = BR_W'(blk_conds);
		r.exit_path          = path;
		r.next_block_pc      = succ;
		r.start_line         = line_no(blk_start);
		r.successor_line     = line_no(succ);
		r.has_predecessor    = prior_ok;
		r.pred_line          = prior_ok ? prior_line : '0;
		r.pred_path          = prior_ok ? prior_path : '0;
		r.follows_zero_block = prior_zero;
		if (blk_conds != 0)
			r.zero_block_kind = KIND_BRANCHY;
		else if (succ == blk_start + (PC_WIDTH'(blk_insts) << 2))
			r.zero_block_kind = KIND_SEQ;
		else
			r.zero_block_kind = KIND_JUMP;
		prior_zero = (blk_conds == 0);
		prior_line = r.start_line;
		prior_path = path;
		prior_ok   = 1'b1;
		blk_open   = 1'b0;
		blk_insts  = 0;
		blk_conds  = 0;
		return r;
	endfunction

	// advances the trace state by one request, returns 1 when a block closes
	function automatic bit cut_trace(input fbf_item_t it, output fbf_result_t r);
		int unsigned lines;
		int unsigned cur;
		bit tk;
		bit line_done;
		bit limit;
		lines = 1 << span_log();
		r = '0;
		if (it.mode == MODE_FLUSH) begin
			if (blk_open && prev_ok) begin
				r = retire_block(prev_pc + 64'd4, 1'b0);
				return 1'b1;
			end
			return 1'b0;
		end
		tk = it.taken_flag;
		if (prev_ok && it.pc != prev_pc + 64'd4)
			tk = 1'b1;
		if (!blk_open) begin
			blk_start  = it.pc;
			blk_offset = 32'((it.pc >> 2) & PC_WIDTH'(lines - 1));
			blk_insts  = 0;
			blk_open   = 1'b1;
		end
		if (blk_insts < 511)
			blk_insts++;
		if (it.is_cond_branch && blk_conds < 15)
			blk_conds++;
		tk        = it.is_branch && tk;
		cur       = blk_offset + blk_insts - 1;
		line_done = (cur >= lines - 1);
		limit     = it.is_cond_branch && (blk_conds >= cfg_max_cond);
		prev_pc   = it.pc;
		prev_ok   = 1'b1;
		if (tk || line_done || limit) begin
			r = retire_block(tk ? it.next_pc : it.pc + 64'd4, tk);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic fbf_result_t mk_result(input logic [63:0] spc, input int unsigned cnt,
			input int unsigned conds, input int unsigned path, input logic [63:0] succ,
			input logic [LINE_WIDTH-1:0] sl, input logic [LINE_WIDTH-1:0] nl, input bit hp,
			input logic [LINE_WIDTH-1:0] pl, input int unsigned pp,
			input logic [KIND_W-1:0] kind, input bit fz);
		fbf_result_t r;
		r.start_pc           = spc;
		r.instr_count        = COUNT_W'(cnt);
		r.cond_count         = BR_W'(conds);
		r.exit_path          = BR_W'(path);
		r.next_block_pc      = succ;
		r.start_line         = sl;
		r.successor_line     = nl;
		r.has_predecessor    = hp;
		r.pred_line          = pl;
		r.pred_path          = BR_W'(pp);
		r.zero_block_kind    = kind;
		r.follows_zero_block = fz;
		return r;
	endfunction

	task automatic add_row(input logic md, input logic [63:0] p, input logic [63:0] np,
			input logic br, input logic cb, input logic tk, input bit typed,
			input fbf_result_t want);
		dir_row_t row;
		row.req.mode           = md;
		row.req.pc             = p;
		row.req.next_pc        = np;
		row.req.is_branch      = br;
		row.req.is_cond_branch = cb;
		row.req.taken_flag     = tk;
		row.typed              = typed;
		row.want               = want;
		dir_rows.insert(dir_rows.size(), row);
	endtask

	function automatic fbf_item_t next_trace_item();
		fbf_item_t it;
		int unsigned pick;
		bit jump;
		it.mode           = 1'b0;
		it.pc             = trace_pc;
		it.next_pc        = {$urandom, $urandom};
		it.is_branch      = 1'b0;
		it.is_cond_branch = 1'b0;
		it.taken_flag     = 1'($urandom_range(0, 1));
		jump = 1'b0;
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			it.mode           = MODE_FLUSH;
			it.pc             = {$urandom, $urandom};
			it.is_branch      = 1'($urandom_range(0, 1));
			it.is_cond_branch = 1'($urandom_range(0, 1));
			return it;
		end
		if (pick < 12) begin
			// off-trace noise
			it.pc             = {$urandom, $urandom};
			it.is_branch      = 1'($urandom_range(0, 1));
			it.is_cond_branch = 1'($urandom_range(0, 1));
			trace_pc          = it.pc + 64'd4;
			return it;
		end
		if (pick < 60) begin
			jump = 1'b0;
		end else if (pick < 82) begin
			it.is_branch      = 1'b1;
			it.is_cond_branch = 1'b1;
			jump              = ($urandom_range(0, 2) == 0);
		end else if (pick < 94) begin
			it.is_branch = 1'b1;
			jump         = 1'b1;
		end else begin
			it.is_branch = 1'b1;
		end
		if (jump) begin
			if ($urandom_range(0, 1))
				it.next_pc = trace_pc + (64'($urandom_range(0, 127)) << 2) - 64'd256;
			it.taken_flag = ($urandom_range(0, 9) != 0);
			trace_pc      = it.next_pc;
		end else begin
			if (it.is_branch)
				it.taken_flag = 1'b0;
			trace_pc = trace_pc + 64'd4;
		end
		return it;
	endfunction

	task automatic push_request(input fbf_item_t it, input bit typed, input fbf_result_t want);
		fbf_result_t r;
		item_valid     <= 1'b1;
		mode           <= it.mode;
		pc             <= it.pc;
		next_pc        <= it.next_pc;
		is_branch      <= it.is_branch;
		is_cond_branch <= it.is_cond_branch;
		taken_flag     <= it.taken_flag;
		do @(posedge clk); while (!item_ready);
		if (cut_trace(it, r))
			pending_blocks.insert(pending_blocks.size(), typed ? want : r);
		else if (typed)
			pending_blocks.insert(pending_blocks.size(), want);
	endtask

	// bursts of requests separated by random gaps
	task automatic pace();
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				item_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (pending_blocks.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic program_cfg(input logic [CFG_W-1:0] lg, input logic [CFG_W-1:0] mc);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_LOG_LINE;
		cfg_data  <= lg;
		@(posedge clk);
		cfg_index <= CFG_MAX_COND;
		cfg_data  <= mc;
		@(posedge clk);
		cfg_we       <= 1'b0;
		cfg_log_line = lg;
		cfg_max_cond = mc;
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %h actual %h", name, want, got);
		end
	endtask

	always @(posedge clk) begin : monitor
		fbf_result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_blocks.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected block start_pc %h", start_pc);
			end else begin
				want = pending_blocks.pop_front();
				check_field("start_pc", want.start_pc, start_pc);
				check_field("instr_count", 64'(want.instr_count), 64'(instr_count));
				check_field("cond_count", 64'(want.cond_count), 64'(cond_count));
				check_field("exit_path", 64'(want.exit_path), 64'(exit_path));
				check_field("next_block_pc", want.next_block_pc, next_block_pc);
				check_field("start_line", 64'(want.start_line), 64'(start_line));
				check_field("successor_line", 64'(want.successor_line),
					64'(successor_line));
				check_field("has_predecessor", 64'(want.has_predecessor),
					64'(has_predecessor));
				check_field("pred_line", 64'(want.pred_line), 64'(pred_line));
				check_field("pred_path", 64'(want.pred_path), 64'(pred_path));
				check_field("zero_block_kind", 64'(want.zero_block_kind),
					64'(zero_block_kind));
				check_field("follows_zero_block", 64'(want.follows_zero_block),
					64'(follows_zero_block));
			end
		end
	end

	initial begin : sink
		sink_style_t style;
		int unsigned left;
		style = SINK_OPEN;
		left  = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_go && !hold_off_done) begin
				// long stall so the block backs up into the request side
				result_ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_off_done = 1'b1;
			end else begin
				if (left == 0) begin
					style = sink_style_t'($urandom_range(0, 3));
					left  = $urandom_range(8, 80);
				end
				left--;
				case (style)
					SINK_OPEN:     result_ready <= 1'b1;
					SINK_MOSTLY:   result_ready <= ($urandom_range(0, 3) != 0);
					SINK_SPARSE:   result_ready <= ($urandom_range(0, 3) == 0);
					SINK_PERIODIC: result_ready <= (left % 3 == 0);
					default:       result_ready <= 1'b1;
				endcase
			end
		end
	end

	initial begin : stimulus
		fbf_item_t   it;
		logic [63:0] base;
		int          ph;
		int          n;
		ph_log = '{4'd0, 4'd8, 4'd15, 4'd2, 4'd9, 4'd4, 4'd1};
		ph_max = '{4'd1, 4'd15, 4'd0, 4'd3, 4'd5, 4'd15, 4'd1};

		// flush with nothing open
		add_row(MODE_FLUSH, 64'h0, 64'h0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
		add_row(1'b0, 64'h1000, 64'h0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
		add_row(1'b0, 64'h1004, 64'h2000, 1'b1, 1'b0, 1'b1, 1'b1,
			mk_result(64'h1000, 2, 0, 0, 64'h2000, 62'h10, 62'h20, 1'b0, '0, 0,
			KIND_JUMP, 1'b0));
		// pc jump makes this branch taken
		add_row(1'b0, 64'h2000, 64'h3000, 1'b1, 1'b1, 1'b0, 1'b0, '0);
		add_row(1'b0, 64'h3000, 64'h0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
		for (n = 1; n <= 7; n++)
			add_row(1'b0, 64'h3000 + 64'(n * 4), 64'h0, 1'b1, 1'b1, 1'b0, 1'b0, '0);
		// last slot of a line
		add_row(1'b0, 64'h30fc, 64'h0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
		add_row(1'b0, 64'hffff_ffff_ffff_fff8, 64'h0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
		// pc + 4 wraps to zero
		add_row(1'b0, 64'hffff_ffff_ffff_fffc, 64'h0, 1'b0, 1'b0, 1'b0, 1'b1,
			mk_result(64'hffff_ffff_ffff_fff8, 2, 0, 0, 64'h0, 62'h00ff_ffff_ffff_ffff, '0,
			1'b1, 62'h30, 0, KIND_SEQ, 1'b1));
		add_row(1'b0, 64'h0, 64'hffff_ffff_ffff_ffff, 1'b1, 1'b1, 1'b0, 1'b0, '0);
		add_row(1'b0, 64'h4, 64'hffff_ffff_ffff_ffff, 1'b1, 1'b0, 1'b1, 1'b0, '0);
		add_row(1'b0, 64'hffff_ffff_ffff_ffff, 64'h0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
		add_row(1'b0, 64'h3, 64'h0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
		add_row(MODE_FLUSH, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b1, 1'b1, 1'b1,
			1'b0, '0);
		add_row(1'b0, 64'h7, 64'hffff_ffff_0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, '0);
		add_row(1'b0, 64'h0123_4567_89ab_cdef, 64'h0, 1'b0, 1'b0, 1'b1, 1'b0, '0);
		add_row(MODE_FLUSH, 64'h0, 64'h0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
		add_row(MODE_FLUSH, 64'h0, 64'h0, 1'b0, 1'b0, 1'b0, 1'b0, '0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			push_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
			pace();
		end

		for (ph = 0; ph < PHASES; ph++) begin
			drain();
			program_cfg(ph_log[ph], ph_max[ph]);
			if (ph == 0)
				hold_off_go = 1'b1;
			if ($urandom_range(0, 1))
				trace_pc = {$urandom, $urandom};
			else if ($urandom_range(0, 1))
				trace_pc = 64'hffff_ffff_ffff_ff00 | 64'($urandom_range(0, 255));
			else
				trace_pc = {32'h0, $urandom};
			if (ph_log[ph] == MAX_LINE_LOG) begin
				// one full-size line with no branches
				it = '0;
				it.mode    = MODE_FLUSH;
				it.next_pc = {$urandom, $urandom};
				push_request(it, 1'b0, '0);
				base = {$urandom, $urandom} & ~64'h3ff;
				for (n = 0; n < 256; n++) begin
					it = '0;
					it.pc         = base + 64'(n * 4);
					it.next_pc    = {$urandom, $urandom};
					it.taken_flag = 1'($urandom_range(0, 1));
					push_request(it, 1'b0, '0);
					pace();
				end
				trace_pc = base + 64'h400;
			end
			for (n = 0; n < 80; n++) begin
				push_request(next_trace_item(), 1'b0, '0);
				pace();
			end
		end

		drain();
		if (mismatches == 0 && pending_blocks.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
